>>> sv/ocx_pkg.sv
// ----------------------------------------------------------------------------
// ocx_pkg
// Shared types, constants and helper functions of the octree cell index block.
// ----------------------------------------------------------------------------
package ocx_pkg;

	localparam int COORD_BITS = 8;
	localparam int MAX_DEPTH  = 8;
	localparam int CODE_W     = 3 * COORD_BITS;
	localparam int IDX_W      = 25;
	localparam int NUM_W      = 34;   // magnitude of corner minus origin
	localparam int DIV_W      = 31;   // cell size
	localparam int DIV_STEPS  = NUM_W;
	localparam int LANES      = 6;    // lo x/y/z, hi x/y/z

	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_CELL_X   = 3'd3,
		REG_CELL_Y   = 3'd4,
		REG_CELL_Z   = 3'd5,
		REG_DEPTH    = 3'd6
	} ocx_reg_t;

	typedef enum logic [1:0] {
		FUNC_BOX    = 2'd0,
		FUNC_TRI    = 2'd1,
		FUNC_SPHERE = 2'd2
	} ocx_func_t;

	// one division in flight
	typedef struct packed {
		logic [NUM_W-1:0]      num;
		logic [DIV_W-1:0]      rem;
		logic [COORD_BITS-1:0] quo;
		logic                  neg;
	} ocx_lane_t;

	typedef ocx_lane_t [LANES-1:0] ocx_lanes_t;

	function automatic logic [CODE_W-1:0] spread3(input logic [COORD_BITS-1:0] v);
		logic [CODE_W-1:0] r;
		r = '0;
		for (int i = 0; i < COORD_BITS; i++) begin
			r[3*i] = v[i];
		end
		return r;
	endfunction

	// (8^k - 1) / 7
	function automatic logic [IDX_W-1:0] octal_sum(input logic [3:0] k);
		logic [IDX_W-1:0] s;
		unique case (k)
			4'd0: s = 25'd0;
			4'd1: s = 25'd1;
			4'd2: s = 25'd9;
			4'd3: s = 25'd73;
			4'd4: s = 25'd585;
			4'd5: s = 25'd4681;
			4'd6: s = 25'd37449;
			4'd7: s = 25'd299593;
			4'd8: s = 25'd2396745;
			4'd9: s = 25'd19173961;
			default: s = 25'd0;
		endcase
		return s;
	endfunction

endpackage

>>> sv/ocx_div_cell.sv
// ----------------------------------------------------------------------------
// ocx_div_cell
// One restoring division step for all six corner coordinates.
// ----------------------------------------------------------------------------
module ocx_div_cell
	import ocx_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  ocx_lanes_t                 in_lanes,
	input  logic [2:0][DIV_W-1:0]      divisor,
	output logic                       out_valid,
	output ocx_lanes_t                 out_lanes
);

	ocx_lanes_t lanes_d;
	logic       valid_q;
	ocx_lanes_t lanes_q;

	always_comb begin
		logic [DIV_W:0] trial;
		logic [DIV_W:0] dv;
		logic           ge;
		for (int l = 0; l < LANES; l++) begin
			dv    = {1'b0, divisor[l % 3]};
			trial = {in_lanes[l].rem, in_lanes[l].num[NUM_W-1]};
			ge    = trial >= dv;
			lanes_d[l].num = {in_lanes[l].num[NUM_W-2:0], 1'b0};
			lanes_d[l].rem = ge ? DIV_W'(trial - dv) : trial[DIV_W-1:0];
			lanes_d[l].quo = {in_lanes[l].quo[COORD_BITS-2:0], ge};
			lanes_d[l].neg = in_lanes[l].neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lanes_q <= lanes_d;
		end
	end

	assign out_valid = valid_q;
	assign out_lanes = lanes_q;

endmodule

>>> sv/ocx_front.sv
// ----------------------------------------------------------------------------
// ocx_front
// Bounding box of the shape, then signed offset from origin split into
// magnitude and sign for the divider chain.
// ----------------------------------------------------------------------------
module ocx_front
	import ocx_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [1:0]            func,
	input  logic [2:0][31:0]      first,
	input  logic [2:0][31:0]      second,
	input  logic [2:0][31:0]      third,
	input  logic [30:0]           radius,
	input  logic [2:0][31:0]      origin,
	output logic                  out_valid,
	output ocx_lanes_t            out_lanes
);

	logic              valid_s1;
	logic [2:0][32:0]  lo_s1;
	logic [2:0][32:0]  hi_s1;
	logic              valid_s2;
	ocx_lanes_t        lanes_s2;

	logic [2:0][32:0]  lo_d;
	logic [2:0][32:0]  hi_d;
	ocx_lanes_t        lanes_d;

	always_comb begin
		logic signed [32:0] f, s, t, r, lo, hi;
		for (int a = 0; a < 3; a++) begin
			f  = $signed({first[a][31], first[a]});
			s  = $signed({second[a][31], second[a]});
			t  = $signed({third[a][31], third[a]});
			r  = $signed({2'b00, radius});
			lo = f;
			hi = s;
			if (func == FUNC_TRI) begin
				lo = f;
				hi = f;
				if (s < lo) lo = s;
				if (t < lo) lo = t;
				if (s > hi) hi = s;
				if (t > hi) hi = t;
			end else if (func == FUNC_SPHERE) begin
				lo = f - r;
				hi = f + r;
			end
			lo_d[a] = lo;
			hi_d[a] = hi;
		end
	end

	always_comb begin
		logic signed [NUM_W-1:0] d;
		logic [32:0]             b;
		for (int l = 0; l < LANES; l++) begin
			b = (l < 3) ? lo_s1[l % 3] : hi_s1[l % 3];
			d = $signed({b[32], b}) - $signed({{2{origin[l % 3][31]}}, origin[l % 3]});
			lanes_d[l].neg = d[NUM_W-1];
			lanes_d[l].num = d[NUM_W-1] ? NUM_W'(-d) : NUM_W'(d);
			lanes_d[l].rem = '0;
			lanes_d[l].quo = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1    <= lo_d;
			hi_s1    <= hi_d;
			lanes_s2 <= lanes_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_lanes = lanes_s2;

endmodule

>>> sv/octree_cell_index.sv
// ----------------------------------------------------------------------------
// octree_cell_index
// Linear octree node index of a box, triangle or sphere via 3-D Morton codes.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------
//   input    | in_valid / in_ready | func, first_*, second_*, third_*, radius
//   output   | out_valid/out_ready | cell_index, outside
//   config   | cfg_we              | cfg_idx, cfg_data
//
// One transaction per cycle while the output is not stalled; stages: two front stages, one
// divider cell per numerator bit (34), Morton/level stage, output register.
// Reset clears valid bits and loads register defaults.
// The whole pipeline stalls while the output register holds an untaken result.
// ----------------------------------------------------------------------------
module octree_cell_index
	import ocx_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic signed [31:0] first_x,
	input  logic signed [31:0] first_y,
	input  logic signed [31:0] first_z,
	input  logic signed [31:0] second_x,
	input  logic signed [31:0] second_y,
	input  logic signed [31:0] second_z,
	input  logic signed [31:0] third_x,
	input  logic signed [31:0] third_y,
	input  logic signed [31:0] third_z,
	input  logic [30:0]        radius,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [IDX_W-1:0]   cell_index,
	output logic               outside,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_data
);

	logic [2:0][31:0]      origin_q;
	logic [2:0][DIV_W-1:0] cell_q;
	logic [3:0]            depth_q;
	logic [2:0][DIV_W-1:0] divisor;
	logic                  adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			cell_q   <= {3{31'd1}};
			depth_q  <= 4'd8;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ORIGIN_X: origin_q[0] <= cfg_data;
				REG_ORIGIN_Y: origin_q[1] <= cfg_data;
				REG_ORIGIN_Z: origin_q[2] <= cfg_data;
				REG_CELL_X:   cell_q[0]   <= cfg_data[DIV_W-1:0];
				REG_CELL_Y:   cell_q[1]   <= cfg_data[DIV_W-1:0];
				REG_CELL_Z:   cell_q[2]   <= cfg_data[DIV_W-1:0];
				REG_DEPTH:    depth_q     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// zero cell size acts as one
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			divisor[a] = (cell_q[a] == '0) ? DIV_W'(1) : cell_q[a];
		end
	end

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	logic       fr_valid;
	ocx_lanes_t fr_lanes;

	ocx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (in_valid),
		.func      (func),
		.first     ({first_z, first_y, first_x}),
		.second    ({second_z, second_y, second_x}),
		.third     ({third_z, third_y, third_x}),
		.radius    (radius),
		.origin    (origin_q),
		.out_valid (fr_valid),
		.out_lanes (fr_lanes)
	);

	logic       chain_valid [DIV_STEPS+1];
	ocx_lanes_t chain_lanes [DIV_STEPS+1];

	assign chain_valid[0] = fr_valid;
	assign chain_lanes[0] = fr_lanes;

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		ocx_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (chain_valid[g]),
			.in_lanes  (chain_lanes[g]),
			.divisor   (divisor),
			.out_valid (chain_valid[g+1]),
			.out_lanes (chain_lanes[g+1])
		);
	end

	// Morton codes and level
	logic [CODE_W-1:0] lo_code, hi_code, diff;
	logic [3:0]        level;

	always_comb begin
		logic [LANES-1:0][COORD_BITS-1:0] q;
		ocx_lanes_t                       ln;
		ln = chain_lanes[DIV_STEPS];
		for (int l = 0; l < LANES; l++) begin
			q[l] = ln[l].neg ? COORD_BITS'(-ln[l].quo) : ln[l].quo;
		end
		lo_code = spread3(q[0]) | (spread3(q[1]) << 1) | (spread3(q[2]) << 2);
		hi_code = spread3(q[3]) | (spread3(q[4]) << 1) | (spread3(q[5]) << 2);
		diff    = lo_code ^ hi_code;
		level   = 4'd0;
		for (int g = 0; g < COORD_BITS; g++) begin
			if (|diff[3*g +: 3]) level = 4'(g + 1);
		end
	end

	logic              valid_s3;
	logic [CODE_W-1:0] code_s3;
	logic [3:0]        level_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= chain_valid[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			code_s3  <= hi_code;
			level_s3 <= level;
		end
	end

	// node index
	logic [3:0]       depth_eff;
	logic [4:0]       shamt;
	logic [IDX_W-1:0] idx;
	logic [IDX_W-1:0] size;
	logic             over;

	always_comb begin
		depth_eff = (depth_q > 4'(MAX_DEPTH)) ? 4'(MAX_DEPTH) : depth_q;
		shamt     = {level_s3, 1'b0} + 5'(level_s3);
		idx       = IDX_W'(code_s3 >> shamt);
		if (level_s3 <= depth_eff) begin
			idx = idx + octal_sum(depth_eff - level_s3);
		end
		size = octal_sum(depth_eff + 4'd1);
		over = idx >= size;
	end

	logic             out_valid_q;
	logic [IDX_W-1:0] index_q;
	logic             outside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			index_q   <= over ? '0 : idx;
			outside_q <= over;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_index = index_q;
	assign outside    = outside_q;

	a_outside_root: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outside |-> cell_index == '0)
		else $error("outside result carries a nonzero index");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("pipeline stalled without a waiting result");

	a_index_in_tree: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !outside |-> cell_index < size)
		else $error("index beyond tree size not flagged");

	a_hold_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(valid_s3) && $stable(chain_valid[DIV_STEPS]))
		else $error("internal stage moved during stall");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the octree cell index block: boxes, triangles and spheres are sent
// under several origin / cell size / depth settings, and every node index is
// compared in order against a predictor of the Morton binning.
// ----------------------------------------------------------------------------
module tb_top;
	import ocx_pkg::*;

	typedef struct {
		logic [1:0]         func;
		logic signed [31:0] f [3];
		logic signed [31:0] s [3];
		logic signed [31:0] t [3];
		logic [30:0]        rad;
	} shape_t;

	typedef struct {
		logic [24:0] idx;
		logic        outside;
	} node_t;

	// configuration copy held by the predictor
	logic signed [31:0] org [3];
	logic [30:0]        csz [3];
	logic [3:0]         depth_r;

	function automatic logic [7:0] to_cell(longint p, int a);
		longint d, c, q;
		d = p - longint'(org[a]);
		c = (csz[a] == 0) ? 1 : longint'(csz[a]);
		q = d / c;
		return q[7:0];
	endfunction

	function automatic logic [23:0] interleave(longint p [3]);
		logic [23:0] r;
		logic [7:0]  v [3];
		r = '0;
		for (int a = 0; a < 3; a++) v[a] = to_cell(p[a], a);
		for (int i = 0; i < 8; i++)
			for (int a = 0; a < 3; a++) r[3*i+a] = v[a][i];
		return r;
	endfunction

	function automatic longint octsum(int k);
		longint s;
		s = 0;
		for (int i = 0; i < k; i++) s += longint'(1) << (3*i);
		return s;
	endfunction

	function automatic node_t bin_shape(shape_t sh);
		longint lo [3], hi [3], f, s, t, idx;
		logic [23:0] lc, hc, diff;
		int lvl, dep;
		node_t n;
		for (int a = 0; a < 3; a++) begin
			f = sh.f[a]; s = sh.s[a]; t = sh.t[a];
			if (sh.func == FUNC_TRI) begin
				lo[a] = f; hi[a] = f;
				if (s < lo[a]) lo[a] = s;
				if (t < lo[a]) lo[a] = t;
				if (s > hi[a]) hi[a] = s;
				if (t > hi[a]) hi[a] = t;
			end else if (sh.func == FUNC_SPHERE) begin
				lo[a] = f - longint'(sh.rad);
				hi[a] = f + longint'(sh.rad);
			end else begin
				lo[a] = f; hi[a] = s;
			end
		end
		lc = interleave(lo);
		hc = interleave(hi);
		lvl = 0;
		for (diff = lc ^ hc; diff != 0; diff = diff >> 3) lvl++;
		dep = (depth_r > MAX_DEPTH) ? MAX_DEPTH : depth_r;
		idx = longint'(hc) >> (3*lvl);
		if (lvl <= dep) idx += octsum(dep - lvl);
		if (idx >= octsum(dep + 1)) begin
			n.idx = 0; n.outside = 1;
		end else begin
			n.idx = idx[24:0]; n.outside = 0;
		end
		return n;
	endfunction

	class node_board;
		node_t pending[$];
		int errors = 0;
		int checked = 0;
		function void note_shape(shape_t sh);
			pending = {pending, bin_shape(sh)};
		endfunction
		function void check_node(logic [24:0] idx, logic outside);
			node_t e;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected node %0d/%0b", $time, idx, outside);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (idx !== e.idx) begin
				$display("%0t: cell_index exp %0d got %0d", $time, e.idx, idx);
				errors++;
			end
			if (outside !== e.outside) begin
				$display("%0t: outside exp %0b got %0b", $time, e.outside, outside);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, outside, cfg_we;
	logic [1:0] func;
	logic signed [31:0] first_x, first_y, first_z, second_x, second_y, second_z;
	logic signed [31:0] third_x, third_y, third_z;
	logic [30:0] radius;
	logic [24:0] cell_index;
	logic [2:0] cfg_idx;
	logic [31:0] cfg_data;

	node_board board;
	bit calm;
	longint cycles;
	int sent;

	octree_cell_index DUT (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("octree_cell_index: mismatch");
				$finish;
			end
		end
	end

	// result side: random stall bursts, checks at each accepted transaction
	initial begin
		int burst;
		out_ready = 0;
		burst = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) board.check_node(cell_index, outside);
			if (burst > 0) begin
				burst--; out_ready <= 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 14) - 1; out_ready <= 0;
			end else out_ready <= 1;
		end
	end

	task automatic write_reg(ocx_reg_t r, logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1; cfg_idx <= r; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		if (r < REG_CELL_X) org[r] = v;
		else if (r < REG_DEPTH) csz[r - REG_CELL_X] = v[30:0];
		else depth_r = v[3:0];
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 4000) - 2000;
			default: return {$urandom_range(0, 1) ? 32'h7fffff00 : 32'h80000000}
				+ $urandom_range(0, 255);
		endcase
	endfunction

	function automatic shape_t rnd_shape();
		shape_t sh;
		int m;
		m = $urandom_range(0, 9) < 7 ? 1 : ($urandom_range(0, 3) == 0 ? 2 : 0);
		sh.func = 2'($urandom_range(0, 3));
		for (int a = 0; a < 3; a++) begin
			sh.f[a] = rnd_coord(m);
			sh.s[a] = (m == 1) ? sh.f[a] + $urandom_range(0, 64) : rnd_coord(m);
			sh.t[a] = rnd_coord(m);
		end
		sh.rad = 31'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 200));
		return sh;
	endfunction

	// valid stays high between back-to-back transactions; it drops only for idling
	task automatic send(shape_t sh);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1; func <= sh.func; radius <= sh.rad;
		first_x <= sh.f[0]; first_y <= sh.f[1]; first_z <= sh.f[2];
		second_x <= sh.s[0]; second_y <= sh.s[1]; second_z <= sh.s[2];
		third_x <= sh.t[0]; third_y <= sh.t[1]; third_z <= sh.t[2];
		do @(posedge clk); while (!in_ready);
		board.note_shape(sh);
		sent++;
	endtask

	task automatic directed();
		shape_t sh;
		logic signed [31:0] ext [4];
		ext = '{32'sh7fffffff, 32'sh80000000, 0, -1};
		for (int k = 0; k < 16; k++) begin
			sh.func = 2'(k % 4);
			for (int a = 0; a < 3; a++) begin
				sh.f[a] = ext[k % 4];
				sh.s[a] = ext[(k / 4) % 4];
				sh.t[a] = ext[(k + a) % 4];
			end
			sh.rad = (k % 3 == 0) ? 31'h7fffffff : 31'(k);
			send(sh);
		end
		// swapped box corners, small triangle, sphere radius zero
		sh.func = FUNC_BOX;
		for (int a = 0; a < 3; a++) begin sh.f[a] = 100; sh.s[a] = 3; sh.t[a] = 7; end
		send(sh);
		sh.func = FUNC_TRI; send(sh);
		sh.func = FUNC_SPHERE; sh.rad = 0; send(sh);
	endtask

	initial begin
		logic [31:0] o [3], c [3];
		logic [3:0] d;
		board = new();
		calm = 0; sent = 0;
		arst_n = 0; in_valid = 0; cfg_we = 0; cfg_idx = 0; cfg_data = 0;
		func = 0; radius = 0;
		first_x = 0; first_y = 0; first_z = 0; second_x = 0; second_y = 0;
		second_z = 0; third_x = 0; third_y = 0; third_z = 0;
		for (int a = 0; a < 3; a++) begin org[a] = 0; csz[a] = 1; end
		depth_r = 8;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		directed();
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			for (int a = 0; a < 3; a++) begin
				case (ph % 4)
					0: begin o[a] = 32'h80000000; c[a] = 0; end
					1: begin o[a] = 32'h7fffffff; c[a] = 32'h7fffffff; end
					2: begin o[a] = $urandom_range(0, 2000) - 1000;
						c[a] = $urandom_range(1, 16); end
					default: begin o[a] = $urandom; c[a] = $urandom; end
				endcase
				write_reg(ocx_reg_t'(REG_ORIGIN_X + a), o[a]);
				write_reg(ocx_reg_t'(REG_CELL_X + a), c[a]);
			end
			d = (ph == 0) ? 4'd0 : (ph == 1) ? 4'd15 : (ph == 2) ? 4'd8 :
				4'($urandom_range(0, 15));
			write_reg(REG_DEPTH, {28'd0, d});
			if (ph == 7) calm = 1;
			repeat (110) send(rnd_shape());
		end
		drain();
		$display("Sent %0d shapes over 8 register settings, %0d nodes checked.",
			sent, board.checked);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("octree_cell_index: match");
		else
			$display("octree_cell_index: mismatch");
		$finish;
	end
endmodule
